@@ hw/rtl/swhc_pkg.sv @@
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared widths, link type and controller states for the sliding window
// hit counter.
// ----------------------------------------------------------------------------
package swhc_pkg;

   localparam int TIME_W  = 31;
   localparam int COUNT_W = 32;
   localparam int TOTAL_W = 41;

   localparam logic MODE_HIT   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // partial sum handed from one bucket cell to the next
   typedef struct packed {
      logic               valid;
      logic [TOTAL_W-1:0] sum;
   } scan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_LAUNCH,
      ST_SCAN,
      ST_PEND
   } state_type;

endpackage

@@ hw/rtl/swhc_mod.sv @@
// ----------------------------------------------------------------------------
// swhc_mod
// Remainder of a timestamp by WINDOW in two register stages: quotient by
// reciprocal multiply, then timestamp minus quotient times WINDOW.
// ----------------------------------------------------------------------------
module swhc_mod #(
   parameter int WINDOW = 300,
   localparam int IDX_W = $clog2(WINDOW)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [swhc_pkg::TIME_W-1:0] dividend,
   output logic                       done,
   output logic [IDX_W-1:0]           remainder
);
   import swhc_pkg::*;

   // ceil(2^SHIFT / WINDOW) is exact for every TIME_W-bit dividend and fits
   // in TIME_W+1 bits for any WINDOW up to 4096
   localparam int                 SHIFT      = TIME_W + IDX_W;
   localparam int                 RECIP_W    = TIME_W + 1;
   localparam int                 PROD_W     = TIME_W + RECIP_W;
   localparam logic [63:0]        RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];

   logic                stage_ff, stage_in;
   logic                done_ff, done_in;
   logic [TIME_W-1:0]   num_ff, num_in;
   logic [TIME_W-1:0]   quot_ff, quot_in;
   logic [IDX_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]   prod;
   logic [TIME_W-1:0]   back;

   always_comb begin
      prod     = {{RECIP_W{1'b0}}, dividend} * {{TIME_W{1'b0}}, RECIP};
      back     = quot_ff * TIME_W'(WINDOW);
      stage_in = start;
      done_in  = stage_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         num_in  = dividend;
         quot_in = TIME_W'(prod >> SHIFT);
      end
      if (stage_ff) begin
         rem_in = IDX_W'(num_ff - back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/swhc_cell.sv @@
// ----------------------------------------------------------------------------
// swhc_cell
// One per-second bucket: count and stamp, hit update, and one link of the
// summing chain.
// ----------------------------------------------------------------------------
module swhc_cell #(
   parameter int WINDOW = 300,
   parameter int INDEX  = 0,
   localparam int IDX_W = $clog2(WINDOW)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        hit_en,
   input  logic [IDX_W-1:0]            hit_slot,
   input  logic [swhc_pkg::TIME_W-1:0] now,
   input  swhc_pkg::scan_type          scan_in,
   output swhc_pkg::scan_type          scan_out
);
   import swhc_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]  stamp_ff, stamp_in;
   scan_type           scan_ff, scan_in_nxt;
   logic [TIME_W-1:0]  age;
   logic               in_win;

   always_comb begin
      count_in = count_ff;
      stamp_in = stamp_ff;
      if (hit_en && hit_slot == IDX_W'(INDEX)) begin
         if (stamp_ff != now) begin
            stamp_in = now;
            count_in = COUNT_W'(1);
         end else if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // stamp in (now - WINDOW, now]
   always_comb begin
      age    = now - stamp_ff;
      in_win = (stamp_ff <= now) && (age < TIME_W'(WINDOW));
      scan_in_nxt.valid = scan_in.valid;
      scan_in_nxt.sum   = in_win ? scan_in.sum + TOTAL_W'(count_ff) : scan_in.sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         stamp_ff      <= '0;
         scan_ff.valid <= 1'b0;
      end else begin
         count_ff      <= count_in;
         stamp_ff      <= stamp_in;
         scan_ff.valid <= scan_in_nxt.valid;
      end
      scan_ff.sum <= scan_in_nxt.sum;
   end

   assign scan_out = scan_ff;

endmodule

@@ hw/rtl/sliding_window_hit_counter_core.sv @@
// Hit: two-stage remainder by WINDOW, then one bucket update, before the
//   next beat is taken.
// Query: the partial sum walks the row of WINDOW bucket cells, one cell per
//   cycle; the total is held until the response slot is free, and the next
//   beat is taken only after it is handed over.
// Synchronous active-high reset zeroes all bucket counts and stamps at once.
// ----------------------------------------------------------------------------
// sliding_window_hit_counter_core
// Per-second circular buckets counting hits over the last WINDOW seconds.
// ----------------------------------------------------------------------------
module sliding_window_hit_counter_core #(
   parameter int WINDOW = 300
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [swhc_pkg::TIME_W-1:0] req_time_sec,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [swhc_pkg::TOTAL_W-1:0] rsp_window_total
);
   import swhc_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);

   state_type          state_ff, state_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [TOTAL_W-1:0] pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic               mod_start;
   logic               mod_done;
   logic [IDX_W-1:0]   slot;
   logic               hit_en;
   scan_type           launch;
   scan_type           link [WINDOW+1];

   assign link[0] = launch;

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      req_ready    = 1'b0;
      mod_start    = 1'b0;
      hit_en       = 1'b0;
      launch.valid = 1'b0;
      launch.sum   = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               time_in = req_time_sec;
               if (req_mode == MODE_HIT) begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end else begin
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               hit_en   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LAUNCH: begin
            launch.valid = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            if (link[WINDOW].valid) begin
               pend_in  = link[WINDOW].sum;
               state_in = ST_PEND;
            end
         end
         ST_PEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      time_ff      <= time_in;
      pend_ff      <= pend_in;
      rsp_total_ff <= rsp_total_in;
   end

   swhc_mod #(
      .WINDOW (WINDOW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (time_in),
      .done      (mod_done),
      .remainder (slot)
   );

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      swhc_cell #(
         .WINDOW (WINDOW),
         .INDEX  (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .hit_en   (hit_en),
         .hit_slot (slot),
         .now      (time_ff),
         .scan_in  (link[k]),
         .scan_out (link[k+1])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_total = rsp_total_ff;

endmodule

@@ verif/tb_sliding_window_hit_counter_core.sv @@
// ----------------------------------------------------------------------------
// tb_sliding_window_hit_counter_core
// Drives hit and query beats into the hit counter and checks every window
// total against a typed value or a bucket-level predictor kept in the bench.
// A short table of probes covers reset state, window edges, the largest
// timestamps and time going backwards. Random runs of mostly nondecreasing
// timestamps follow under two patterns of sender and receiver stalls, then none.
// ----------------------------------------------------------------------------
module tb_sliding_window_hit_counter_core;
   import swhc_pkg::*;

   localparam int unsigned WINDOW   = 300;
   localparam longint      TIME_TOP = 64'd2147483647;
   localparam logic [TIME_W-1:0] T_MAX = '1;
   localparam int unsigned RUN_LEN  = 626;
   localparam int unsigned N_PROBES = 22;

   typedef struct packed {
      logic               mode;
      logic [TIME_W-1:0]  stamp;
      logic               typed;
      logic [TOTAL_W-1:0] total;
   } probe_row_type;

   // typed totals follow from the buckets touched so far in the table
   localparam probe_row_type PROBES [0:N_PROBES-1] = '{
      '{MODE_QUERY, 31'd0,        1'b1, 41'd0},
      '{MODE_QUERY, T_MAX,        1'b1, 41'd0},
      '{MODE_HIT,   31'd0,        1'b0, 41'd0},
      '{MODE_QUERY, 31'd0,        1'b1, 41'd1},
      '{MODE_HIT,   31'd0,        1'b0, 41'd0},
      '{MODE_HIT,   31'd299,      1'b0, 41'd0},
      '{MODE_QUERY, 31'd299,      1'b1, 41'd3},
      '{MODE_QUERY, 31'd300,      1'b1, 41'd1},
      '{MODE_QUERY, 31'd598,      1'b1, 41'd1},
      '{MODE_QUERY, 31'd599,      1'b1, 41'd0},
      '{MODE_HIT,   31'd300,      1'b0, 41'd0},
      '{MODE_QUERY, 31'd300,      1'b1, 41'd2},
      '{MODE_HIT,   T_MAX,        1'b0, 41'd0},
      '{MODE_HIT,   T_MAX,        1'b0, 41'd0},
      '{MODE_QUERY, T_MAX,        1'b1, 41'd2},
      '{MODE_HIT,   31'd5,        1'b0, 41'd0},
      '{MODE_QUERY, 31'd5,        1'b0, 41'd0},
      '{MODE_QUERY, 31'd299,      1'b0, 41'd0},
      '{MODE_HIT,   T_MAX - 31'd1,   1'b0, 41'd0},
      '{MODE_HIT,   T_MAX - 31'd300, 1'b0, 41'd0},
      '{MODE_QUERY, T_MAX,        1'b0, 41'd0},
      '{MODE_QUERY, 31'h4000_0000, 1'b0, 41'd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = MODE_HIT;
   logic [TIME_W-1:0]  req_time_sec = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [TOTAL_W-1:0] rsp_window_total;

   logic [TIME_W-1:0]  stamp_of [WINDOW];
   logic [COUNT_W-1:0] hits_in  [WINDOW];
   logic [TOTAL_W-1:0] pending_totals [$];

   int unsigned send_idle_pct = 27;
   int unsigned recv_idle_pct = 81;
   int unsigned mismatch_count = 0;

   sliding_window_hit_counter_core #(
      .WINDOW(WINDOW)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_time_sec    (req_time_sec),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_total(rsp_window_total)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #12000000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_buckets();
      for (int k = 0; k < WINDOW; k++) begin
         stamp_of[k] = '0;
         hits_in[k]  = '0;
      end
   endfunction

   function automatic void tally_hit(input logic [TIME_W-1:0] t);
      int unsigned slot;
      slot = t % WINDOW;
      if (stamp_of[slot] != t) begin
         stamp_of[slot] = t;
         hits_in[slot]  = '0;
      end
      if (hits_in[slot] != '1) hits_in[slot]++;
   endfunction

   function automatic logic [TOTAL_W-1:0] window_sum(input logic [TIME_W-1:0] t);
      logic [TOTAL_W-1:0] acc;
      acc = '0;
      // a stamp later than t is skipped, so the subtraction cannot wrap
      for (int k = 0; k < WINDOW; k++)
         if (stamp_of[k] <= t && (t - stamp_of[k]) < WINDOW) acc += hits_in[k];
      return acc;
   endfunction

   function automatic logic [TIME_W-1:0] clamp_time(input longint v);
      if (v < 0) return '0;
      if (v > TIME_TOP) return T_MAX;
      return v[TIME_W-1:0];
   endfunction

   task automatic hold_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // pause until every outstanding total has come back
   task automatic drain_totals();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_totals.size() != 0);
   endtask

   task automatic push_beat(input logic m, input logic [TIME_W-1:0] t,
                            input logic typed, input logic [TOTAL_W-1:0] typed_total);
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_time_sec <= t;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (m == MODE_HIT) tally_hit(t);
      else pending_totals.push_back(typed ? typed_total : window_sum(t));
      if ($urandom_range(99) < send_idle_pct) hold_sender($urandom_range(1, 40));
   endtask

   // runs of nondecreasing seconds with random starting points; a few steps
   // go backwards as noise
   task automatic run_random(input int unsigned n_items);
      int unsigned sent;
      int unsigned seq_left;
      int unsigned r;
      longint      now_s;
      longint      q;
      sent  = 0;
      now_s = 0;
      while (sent < n_items) begin
         case ($urandom_range(3))
            0: now_s = $urandom_range(0, 900);
            1: now_s = $urandom & 32'h7FFF_FFFF;
            2: now_s = TIME_TOP - $urandom_range(0, 2000);
            default: now_s = clamp_time(now_s + $urandom_range(0, 1000));
         endcase
         seq_left = $urandom_range(20, 80);
         while (seq_left > 0 && sent < n_items) begin
            r = $urandom_range(99);
            if (r >= 97) now_s = now_s + $urandom;
            else if (r >= 93) now_s = now_s - longint'($urandom_range(1, 400));
            else if (r >= 88) now_s = now_s + $urandom_range(4, 600);
            else if (r >= 80) now_s = now_s + $urandom_range(299, 301);
            else if (r >= 55) now_s = now_s + $urandom_range(1, 3);
            now_s = clamp_time(now_s);
            if ($urandom_range(99) < 25) begin
               case ($urandom_range(3))
                  0: q = now_s;
                  1: q = now_s + $urandom_range(298, 301);
                  2: q = now_s + $urandom_range(1, 350);
                  default: q = now_s - longint'($urandom_range(0, 5));
               endcase
               push_beat(MODE_QUERY, clamp_time(q), 1'b0, '0);
            end else begin
               push_beat(MODE_HIT, clamp_time(now_s), 1'b0, '0);
            end
            sent++;
            seq_left--;
         end
      end
   endtask

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      logic [TOTAL_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_totals.size() == 0) begin
            flag_mismatch($sformatf("total %0d with no query outstanding",
                                    rsp_window_total));
         end else begin
            want = pending_totals[0];
            pending_totals.delete(0);
            if (rsp_window_total !== want)
               flag_mismatch($sformatf("window_total %0d, want %0d",
                                       rsp_window_total, want));
         end
      end
   end

   initial begin
      clear_buckets();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_PROBES; i++)
         push_beat(PROBES[i].mode, PROBES[i].stamp, PROBES[i].typed, PROBES[i].total);
      drain_totals();

      run_random(RUN_LEN);
      drain_totals();

      send_idle_pct = 81;
      recv_idle_pct = 27;
      run_random(RUN_LEN);
      drain_totals();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RUN_LEN);
      drain_totals();

      // last hit may still be updating its bucket; catch stray beats too
      repeat (WINDOW + TIME_W + 20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
